[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file of the project.
// Needs nothing else; take it in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while rst is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/srlp_pkg.sv]
// Types and constants of the sensor reply line parser.
// No dependencies; used by the interfaces, the top module and the checker.
`default_nettype none

package srlp_pkg;

   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 31;

   // Digit caps and accumulator widths of the two number fields
   localparam int ERR_CAP   = 3;
   localparam int ERR_ACC_W = 10;
   localparam int VAL_CAP   = 9;
   localparam int VAL_ACC_W = 30;

   // Byte positions within a line
   localparam int MARKER_POS    = 2;
   localparam int ERR_START_POS = 4;
   localparam int VAL_START_POS = 4;
   localparam int CAL_START_POS = 5;

   localparam logic [BYTE_W-1:0] CHAR_AT    = 8'h40;
   localparam logic [BYTE_W-1:0] CHAR_QUERY = 8'h3F;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

   typedef enum logic [1:0] {
      KIND_MEASURED = 2'd0,
      KIND_ERROR    = 2'd1,
      KIND_YES      = 2'd2
   } kind_type;

endpackage

`default_nettype wire

[hw/rtl/srlp_if.sv]
// Valid/ready channel interfaces of the sensor reply line parser.
// Depends on srlp_pkg for widths and the reply kind type.
`default_nettype none

interface srlp_req_if;
   logic                           valid;
   logic                           ready;
   logic [srlp_pkg::BYTE_W-1:0]    rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srlp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [srlp_pkg::VALUE_W-1:0] reply_value;
   srlp_pkg::kind_type                 reply_kind;
   logic                               length_cut;

   modport source (output valid, output reply_value, output reply_kind, output length_cut,
                   input ready);
   modport sink   (input valid, input reply_value, input reply_kind, input length_cut,
                   output ready);
endinterface

interface srlp_csr_if;
   logic valid;
   logic ready;
   logic user_calibrated;

   modport source (output valid, output user_calibrated, input ready);
   modport sink   (input valid, input user_calibrated, output ready);
endinterface

`default_nettype wire

[hw/rtl/srlp_atoi.sv]
// One atoi-style number field: skip blanks, optional sign, capped decimal digits.
// Self-contained; instantiated by sensor_reply_line_parser_top.
`default_nettype none

module srlp_atoi #(
   parameter int ACC_W = 10,
   parameter int CAP   = 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,      // item accepted
   input  wire logic             feed,      // byte belongs to this field
   input  wire logic             clear,     // line ends with this item
   input  wire logic [7:0]       rx_byte,
   output logic      [ACC_W-1:0] acc_in,
   output logic                  neg_in
);

   localparam int CNT_W = $clog2(CAP + 1);

   typedef enum logic [1:0] {
      PH_AWAIT,
      PH_NUMBER,
      PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [ACC_W-1:0] acc_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             is_digit, is_blank, take;
   logic [ACC_W-1:0] acc_x10;

   assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
   assign is_blank = (rx_byte == 8'h20) || ((rx_byte >= 8'h09) && (rx_byte <= 8'h0D));
   assign acc_x10  = (acc_ff << 3) + (acc_ff << 1);

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      take     = 1'b0;
      if (feed) begin
         unique case (phase_ff)
            PH_AWAIT: begin
               if (is_blank) begin
                  phase_in = PH_AWAIT;
               end else if (rx_byte == 8'h2B) begin
                  phase_in = PH_NUMBER;
               end else if (rx_byte == 8'h2D) begin
                  neg_in   = 1'b1;
                  phase_in = PH_NUMBER;
               end else begin
                  take     = is_digit;
                  phase_in = is_digit ? PH_NUMBER : PH_DONE;
               end
            end
            PH_NUMBER: begin
               take     = is_digit;
               phase_in = is_digit ? PH_NUMBER : PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
         // Drop digits beyond the cap
         if (take && (cnt_ff < CNT_W'(CAP))) begin
            acc_in = acc_x10 + ACC_W'(rx_byte[3:0]);
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_AWAIT;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
      end else if (step) begin
         if (clear) begin
            phase_ff <= PH_AWAIT;
            neg_ff   <= 1'b0;
            acc_ff   <= '0;
            cnt_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/sensor_reply_line_parser_top.sv]
// Channel  | Dir | Payload                                  | Accepted when
// req_ch   | in  | rx_byte                                  | valid & ready
// rsp_ch   | out | reply_value, reply_kind, length_cut      | valid & ready
// csr_ch   | in  | user_calibrated                          | valid & ready (always ready)
//
// One byte per cycle: each byte is parsed in the cycle it is accepted and a line's
// result is loaded into the output register at the edge that accepts its last byte.
// req_ch stays ready while the output register is empty or being emptied this cycle.
// A result waiting on rsp_ch stalls req_ch until it is taken.
// Synchronous active-high reset clears line state and user_calibrated.
// Depends on srlp_pkg, srlp_if and srlp_atoi.
`default_nettype none

module sensor_reply_line_parser_top #(
   parameter int LINE_LIMIT = 20
) (
   input  wire logic  clock,
   input  wire logic  reset,
   srlp_req_if.sink   req_ch,
   srlp_rsp_if.source rsp_ch,
   srlp_csr_if.sink   csr_ch
);

   import srlp_pkg::*;

   localparam int                POS_W   = $clog2(LINE_LIMIT);
   localparam logic [POS_W-1:0]  CUT_POS = POS_W'(LINE_LIMIT - 2);

   logic                    user_calibrated_ff;
   logic [POS_W-1:0]        pos_ff;
   logic                    prev_cr_ff;
   logic [BYTE_W-1:0]       marker_ff, marker_in;
   logic                    rsp_valid_ff;
   logic [VALUE_W-1:0]      value_ff, value_in;
   kind_type                kind_ff, kind_in;
   logic                    cut_ff;

   logic                    in_fire, crlf, at_cut, line_end;
   logic                    err_feed, val_feed;
   logic [ERR_ACC_W-1:0]    err_acc_in;
   logic                    err_neg_in;
   logic [VAL_ACC_W-1:0]    val_acc_in;
   logic                    val_neg_in;
   logic [BYTE_W-1:0]       c;

   assign c       = req_ch.rx_byte;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign in_fire = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign crlf     = (c == CHAR_LF) && prev_cr_ff && (pos_ff != '0);
   assign at_cut   = !crlf && (pos_ff == CUT_POS);
   assign line_end = crlf || at_cut;

   assign err_feed  = pos_ff >= POS_W'(ERR_START_POS);
   assign val_feed  = pos_ff >= (user_calibrated_ff ? POS_W'(CAL_START_POS)
                                                    : POS_W'(VAL_START_POS));
   assign marker_in = (pos_ff == POS_W'(MARKER_POS)) ? c : marker_ff;

   srlp_atoi #(.ACC_W(ERR_ACC_W), .CAP(ERR_CAP)) u_err (
      .clock   (clock),
      .reset   (reset),
      .step    (in_fire),
      .feed    (err_feed),
      .clear   (line_end),
      .rx_byte (c),
      .acc_in  (err_acc_in),
      .neg_in  (err_neg_in)
   );

   srlp_atoi #(.ACC_W(VAL_ACC_W), .CAP(VAL_CAP)) u_val (
      .clock   (clock),
      .reset   (reset),
      .step    (in_fire),
      .feed    (val_feed),
      .clear   (line_end),
      .rx_byte (c),
      .acc_in  (val_acc_in),
      .neg_in  (val_neg_in)
   );

   // Error code is returned negated; a signed-negative code comes out positive
   always_comb begin
      if ((marker_in == CHAR_AT) && (err_acc_in != '0)) begin
         value_in = err_neg_in ? VALUE_W'(err_acc_in) : -VALUE_W'(err_acc_in);
         kind_in  = KIND_ERROR;
      end else if (marker_in == CHAR_QUERY) begin
         value_in = VALUE_W'(1);
         kind_in  = KIND_YES;
      end else begin
         value_in = val_neg_in ? -VALUE_W'(val_acc_in) : VALUE_W'(val_acc_in);
         kind_in  = KIND_MEASURED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         user_calibrated_ff <= 1'b0;
         pos_ff             <= '0;
         prev_cr_ff         <= 1'b0;
         marker_ff          <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            user_calibrated_ff <= csr_ch.user_calibrated;
         end
         if (in_fire) begin
            if (line_end) begin
               pos_ff     <= '0;
               prev_cr_ff <= 1'b0;
               marker_ff  <= '0;
            end else begin
               pos_ff     <= pos_ff + 1'b1;
               prev_cr_ff <= (c == CHAR_CR);
               marker_ff  <= marker_in;
            end
         end
         if (in_fire && line_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, loaded only when a line closes
   always_ff @(posedge clock) begin
      if (in_fire && line_end) begin
         value_ff <= value_in;
         kind_ff  <= kind_in;
         cut_ff   <= at_cut;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.reply_value = value_ff;
   assign rsp_ch.reply_kind  = kind_ff;
   assign rsp_ch.length_cut  = cut_ff;

endmodule

`default_nettype wire

[hw/rtl/srlp_checker.sv]
// Port-level checks of sensor_reply_line_parser_top, attached by bind.
// Depends on srlp_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module srlp_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [srlp_pkg::VALUE_W-1:0] rsp_value,
   input wire srlp_pkg::kind_type           rsp_kind,
   input wire logic                         rsp_cut
);

   import srlp_pkg::*;

   `ASSERT_CLK(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "result valid after reset")

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_kind) && $stable(rsp_cut), "stalled result changed")

   `ASSERT_CLK_RST(a_ready_when_drained, clock, reset, rsp_ready |-> req_ready, "input stalled while output drains")

   `ASSERT_CLK_RST(a_yes_is_one, clock, reset, rsp_valid && (rsp_kind == KIND_YES) |-> rsp_value == VALUE_W'(1), "yes answer not one")

   `ASSERT_CLK_RST(a_error_nonzero, clock, reset, rsp_valid && (rsp_kind == KIND_ERROR) |-> rsp_value != '0, "device error with zero code")

endmodule

bind sensor_reply_line_parser_top srlp_checker u_srlp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_value (rsp_ch.reply_value),
   .rsp_kind  (rsp_ch.reply_kind),
   .rsp_cut   (rsp_ch.length_cut)
);

`default_nettype wire
